>>> rtl/dtc_pkg.sv
// Shared constants, widths and word types of the derivative threshold crossing core.
`timescale 1ns / 1ps

package dtc_pkg;

    // Sizing of the window and the record
    localparam int MAX_STEP    = 16;
    localparam int MAX_RECORD  = 8192;

    // Field and register widths
    localparam int SMP_W       = 16;
    localparam int DSTEP_W     = 5;
    localparam int CUT_W       = 21;
    localparam int CFG_W       = 21;
    localparam int CFG_IDX_W   = 1;
    localparam int BIN_W       = 13;
    localparam int KIND_W      = 2;

    // Derived sizes
    localparam int CNT_W       = $clog2(MAX_RECORD);
    localparam int STEP_W      = $clog2(MAX_STEP + 1);
    localparam int WIN_DEPTH   = 2 * MAX_STEP + 1;
    localparam int IDX_W       = $clog2(WIN_DEPTH);
    localparam int TREE_LVLS   = $clog2(WIN_DEPTH);
    localparam int TREE_W      = 1 << TREE_LVLS;
    localparam int DER_W       = SMP_W + $clog2(MAX_STEP) + 2;
    localparam int CMP_W       = ((DER_W > CUT_W) ? DER_W : CUT_W) + 1;

    // Result queue
    localparam int OFIFO_DEPTH = 16;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
    localparam int USED_W      = $clog2(OFIFO_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIFF_STEP = 1'b0,
        REG_CUT_LEVEL = 1'b1
    } t_reg_idx;

    // Crossing types
    typedef enum logic [KIND_W-1:0] {
        KIND_UPPER     = 2'd0,
        KIND_LOWER     = 2'd1,
        KIND_DOWN_JUMP = 2'd2,
        KIND_UP_JUMP   = 2'd3
    } t_kind;

    // Window selection for one bin: distance of the bin from the newest sample, half width
    typedef struct packed {
        logic [STEP_W-1:0] offs;
        logic [STEP_W-1:0] half;
    } t_sel;

    // Tag that travels beside the adder tree
    typedef struct packed {
        logic             vld;
        logic             mark;
        logic             zero_bin;
        logic [CNT_W-1:0] bin;
    } t_tag;

    // One result word
    typedef struct packed {
        logic             found;
        logic [BIN_W-1:0] bin;
        t_kind            kind;
        logic             last;
    } t_res;

endpackage

>>> rtl/dtc_cell.sv
// One window cell: holds a sample, passes it on, and weights it for the current bin.
`timescale 1ns / 1ps

module dtc_cell (
    input  logic                               i_clk,
    input  logic                               i_shift,
    input  logic [dtc_pkg::IDX_W-1:0]          i_pos,
    input  dtc_pkg::t_sel                      i_sel,
    input  logic signed [dtc_pkg::SMP_W-1:0]   i_smp,
    output logic signed [dtc_pkg::SMP_W-1:0]   o_smp,
    output logic signed [dtc_pkg::DER_W-1:0]   o_leaf
);
    import dtc_pkg::*;

    localparam int PW = IDX_W + 1;

    logic signed [SMP_W-1:0] r_smp;
    logic [PW-1:0]           pos_x;
    logic [PW-1:0]           dist_x;
    logic [PW-1:0]           half_x;
    logic                    is_fwd;
    logic                    is_back;
    logic signed [DER_W-1:0] smp_x;

    // Advance the window by one sample
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_smp <= i_smp;
        end
    end

    // Newer side of the bin adds, older side subtracts
    always_comb begin
        pos_x   = PW'(i_pos);
        dist_x  = PW'(i_sel.offs);
        half_x  = PW'(i_sel.half);
        is_fwd  = (pos_x < dist_x) && ((pos_x + half_x) >= dist_x);
        is_back = (pos_x > dist_x) && (pos_x <= (dist_x + half_x));
        smp_x   = DER_W'(r_smp);
        if (is_fwd) begin
            o_leaf = smp_x;
        end else if (is_back) begin
            o_leaf = -smp_x;
        end else begin
            o_leaf = '0;
        end
    end

    assign o_smp = r_smp;

endmodule

>>> rtl/dtc_tree.sv
// Pipelined adder tree over the cell leaves, with the bin tag carried alongside.
`timescale 1ns / 1ps

module dtc_tree (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dtc_pkg::t_tag                    i_tag,
    input  logic signed [dtc_pkg::DER_W-1:0] i_leaf [dtc_pkg::TREE_W],
    output dtc_pkg::t_tag                    o_tag,
    output logic signed [dtc_pkg::DER_W-1:0] o_sum
);
    import dtc_pkg::*;

    // Heap order: node m sums nodes 2m and 2m+1, the bottom row sums leaf pairs
    logic signed [DER_W-1:0] r_node [1:TREE_W-1];
    t_tag                    r_tag  [TREE_LVLS];

    // Add one level per cycle
    always_ff @(posedge i_clk) begin
        for (int m = 1; m < TREE_W / 2; m++) begin
            r_node[m] <= r_node[2 * m] + r_node[2 * m + 1];
        end
        for (int m = TREE_W / 2; m < TREE_W; m++) begin
            r_node[m] <= i_leaf[2 * m - TREE_W] + i_leaf[2 * m + 1 - TREE_W];
        end
    end

    // Delay the tag by the depth of the tree
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < TREE_LVLS; s++) begin
                r_tag[s] <= '0;
            end
        end else begin
            r_tag[0] <= i_tag;
            for (int s = 1; s < TREE_LVLS; s++) begin
                r_tag[s] <= r_tag[s - 1];
            end
        end
    end

    assign o_tag = r_tag[TREE_LVLS - 1];
    assign o_sum = r_node[1];

endmodule

>>> rtl/dtc_ofifo.sv
// Result queue between the crossing stage and the output channel.
`timescale 1ns / 1ps

module dtc_ofifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dtc_pkg::t_res i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output dtc_pkg::t_res o_data
);
    import dtc_pkg::*;

    t_res                r_mem [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] r_wr_ptr;
    logic [OFIFO_AW-1:0] r_rd_ptr;
    logic [USED_W-1:0]   r_count;
    logic                do_pop;

    assign o_valid = (r_count != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd_ptr];

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and track the fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + USED_W'(i_push) - USED_W'(do_pop);
        end
    end

endmodule

>>> rtl/derivative_threshold_crossing_core.sv
// Top level: record sequencing, window cells, adder tree, crossing test and result queue.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------------
//   sample   | in        | i_valid / o_ready  | i_sample_value, i_record_end
//   result   | out       | o_valid / i_ready  | o_crossing_found, o_crossing_bin,
//            |           |                    | o_crossing_kind, o_run_last
//   config   | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// Inside a record one sample is taken every cycle while the result queue has room; each
// settled bin goes through a 33-cell window and a six-level registered adder tree before
// its result word reaches the queue. After a record's last sample the sequencer replays
// the unsettled bins one per cycle while the queue has room, then the end marker: the input
// stays not ready until the end marker has been issued. Reset is synchronous, active
// low, and leaves the block ready at once. The input also stalls while the result
// queue has no free entry for every word in flight.
`timescale 1ns / 1ps

module derivative_threshold_crossing_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [dtc_pkg::SMP_W-1:0]    i_sample_value,
    input  logic                                i_record_end,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_crossing_found,
    output logic [dtc_pkg::BIN_W-1:0]           o_crossing_bin,
    output logic [dtc_pkg::KIND_W-1:0]          o_crossing_kind,
    output logic                                o_run_last,
    input  logic                                i_cfg_we,
    input  logic [dtc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dtc_pkg::CFG_W-1:0]           i_cfg_data
);
    import dtc_pkg::*;

    localparam int LW = (CNT_W > STEP_W) ? CNT_W : STEP_W;

    // Clamp the configured step to MAX_STEP, the largest half width of the window
    function automatic logic [STEP_W-1:0] sat_step(input logic [DSTEP_W-1:0] v);
        if (int'(v) > MAX_STEP) begin
            return STEP_W'(MAX_STEP);
        end
        return STEP_W'(v);
    endfunction

    // Smaller of a bin index and a step
    function automatic logic [STEP_W-1:0] min_step(input logic [LW-1:0] a,
                                                   input logic [STEP_W-1:0] b);
        if (a < LW'(b)) begin
            return STEP_W'(a);
        end
        return b;
    endfunction

    // Configuration
    logic [DSTEP_W-1:0]      r_diff_step;
    logic [CUT_W-1:0]        r_cut;

    // Record sequencing
    logic [CNT_W-1:0]        r_cnt;
    logic [STEP_W-1:0]       r_step;
    logic                    r_flush;
    logic                    r_fmark;
    logic [CNT_W-1:0]        r_fbin;
    logic [STEP_W-1:0]       r_fdist;
    logic [USED_W-1:0]       r_used;
    t_sel                    r_sel;
    t_tag                    r_tag;
    t_sel                    n_sel;
    t_tag                    n_tag;
    logic signed [DER_W-1:0] r_prev;

    logic                    in_acc;
    logic                    rec_last;
    logic [STEP_W-1:0]       cur_step;
    logic [LW-1:0]           cnt_l;
    logic [LW-1:0]           step_l;
    logic [LW-1:0]           norm_bin;
    logic                    norm_go;
    logic [LW-1:0]           fl_bin0;
    logic [STEP_W-1:0]       fl_dist0;
    logic                    can_issue;

    // Window and tree
    logic signed [SMP_W-1:0] smp_chain [WIN_DEPTH + 1];
    logic signed [DER_W-1:0] leaf      [TREE_W];
    t_tag                    tr_tag;
    logic signed [DER_W-1:0] tr_sum;

    // Crossing test and queue
    logic signed [CMP_W-1:0] vi;
    logic signed [CMP_W-1:0] vj;
    logic signed [CMP_W-1:0] cut_pos;
    logic signed [CMP_W-1:0] cut_neg;
    logic                    hit;
    t_kind                   kind;
    logic                    res_push;
    logic                    res_drop;
    t_res                    res_word;
    t_res                    out_word;
    logic                    pop;

    // Decode the bin settled by this sample, or the start of a flush
    always_comb begin
        in_acc    = i_valid && o_ready;
        cur_step  = (r_cnt == '0) ? sat_step(r_diff_step) : r_step;
        rec_last  = i_record_end || (r_cnt == CNT_W'(MAX_RECORD - 1));
        cnt_l     = LW'(r_cnt);
        step_l    = LW'(cur_step);
        norm_bin  = cnt_l - step_l;
        norm_go   = in_acc && !rec_last && (cnt_l >= step_l);
        fl_bin0   = (cnt_l >= step_l) ? norm_bin : '0;
        fl_dist0  = min_step(cnt_l, cur_step);
        can_issue = (r_used < USED_W'(OFIFO_DEPTH));
    end

    assign o_ready = !r_flush && can_issue;

    // Pick the next bin request: flush sequencer first, else the live sample
    always_comb begin
        n_tag = '0;
        n_sel = '0;
        if (r_flush && can_issue) begin
            n_tag.vld = 1'b1;
            if (r_fmark) begin
                n_tag.mark = 1'b1;
            end else begin
                n_tag.bin      = r_fbin;
                n_tag.zero_bin = (r_fbin == '0);
                n_sel.offs     = r_fdist;
                n_sel.half     = min_step(LW'(r_fbin), r_fdist);
            end
        end else if (norm_go) begin
            n_tag.vld      = 1'b1;
            n_tag.bin      = CNT_W'(norm_bin);
            n_tag.zero_bin = (norm_bin == '0);
            n_sel.offs     = cur_step;
            n_sel.half     = min_step(norm_bin, cur_step);
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_step <= DSTEP_W'(1);
            r_cut       <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_DIFF_STEP: r_diff_step <= i_cfg_data[DSTEP_W-1:0];
                REG_CUT_LEVEL: r_cut       <= i_cfg_data[CUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample count, latched step and flush sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_step  <= '0;
            r_flush <= 1'b0;
            r_fmark <= 1'b0;
            r_fbin  <= '0;
            r_fdist <= '0;
            r_tag   <= '0;
        end else begin
            r_tag <= n_tag;
            if (in_acc) begin
                r_step <= cur_step;
                r_cnt  <= rec_last ? '0 : r_cnt + 1'b1;
            end
            if (in_acc && rec_last) begin
                r_flush <= 1'b1;
                r_fmark <= 1'b0;
                r_fbin  <= CNT_W'(fl_bin0);
                r_fdist <= fl_dist0;
            end else if (r_flush && can_issue) begin
                if (r_fmark) begin
                    r_flush <= 1'b0;
                end else if (r_fdist == '0) begin
                    r_fmark <= 1'b1;
                end else begin
                    r_fbin  <= r_fbin + 1'b1;
                    r_fdist <= r_fdist - 1'b1;
                end
            end
        end
    end

    // Hold the window selection beside the tag
    always_ff @(posedge i_clk) begin
        r_sel <= n_sel;
    end

    // Row of window cells, newest sample in cell zero
    assign smp_chain[0] = i_sample_value;

    for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_cell
        dtc_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(in_acc),
            .i_pos  (IDX_W'(j)),
            .i_sel  (r_sel),
            .i_smp  (smp_chain[j]),
            .o_smp  (smp_chain[j + 1]),
            .o_leaf (leaf[j])
        );
    end

    for (genvar j = WIN_DEPTH; j < TREE_W; j++) begin : g_pad
        assign leaf[j] = '0;
    end

    dtc_tree u_tree (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tag  (r_tag),
        .i_leaf (leaf),
        .o_tag  (tr_tag),
        .o_sum  (tr_sum)
    );

    // Compare the previous and current derivative against both cuts
    always_comb begin
        vi      = CMP_W'(tr_sum);
        vj      = CMP_W'(r_prev);
        cut_pos = signed'({{(CMP_W - CUT_W){1'b0}}, r_cut});
        cut_neg = -cut_pos;
        hit     = 1'b1;
        kind    = KIND_UPPER;
        if (vj > cut_pos && vi < cut_neg) begin
            kind = KIND_DOWN_JUMP;
        end else if (vj < cut_neg && vi > cut_pos) begin
            kind = KIND_UP_JUMP;
        end else if ((vi > cut_pos && vj < cut_pos) || (vi < cut_pos && vj > cut_pos)) begin
            kind = KIND_UPPER;
        end else if ((vi < cut_neg && vj > cut_neg) || (vi > cut_neg && vj < cut_neg)) begin
            kind = KIND_LOWER;
        end else begin
            hit = 1'b0;
        end

        res_push = tr_tag.vld && (tr_tag.mark || (hit && !tr_tag.zero_bin));
        res_drop = tr_tag.vld && !res_push;

        if (tr_tag.mark) begin
            res_word.found = 1'b0;
            res_word.bin   = '0;
            res_word.kind  = KIND_UPPER;
            res_word.last  = 1'b1;
        end else begin
            res_word.found = 1'b1;
            res_word.bin   = BIN_W'(tr_tag.bin);
            res_word.kind  = kind;
            res_word.last  = 1'b0;
        end
    end

    // Keep the last settled derivative
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (tr_tag.vld && !tr_tag.mark) begin
            r_prev <= tr_sum;
        end
    end

    // Count queue entries that are filled or reserved by words in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= r_used + USED_W'(n_tag.vld) - USED_W'(pop) - USED_W'(res_drop);
        end
    end

    assign pop = o_valid && i_ready;

    dtc_ofifo u_ofifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_word),
        .i_pop  (i_ready),
        .o_valid(o_valid),
        .o_data (out_word)
    );

    assign o_crossing_found = out_word.found;
    assign o_crossing_bin   = out_word.bin;
    assign o_crossing_kind  = out_word.kind;
    assign o_run_last       = out_word.last;

    // A word reaching the queue always has an entry reserved for it
    a_push_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> (r_used != '0))
        else $error("result word pushed without a reserved queue entry");

    // Reservations never exceed the queue
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(OFIFO_DEPTH))
        else $error("queue reservation count overflow");

    // The last sample of a record starts a flush that holds off the input
    a_flush_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && rec_last) |=> !o_ready)
        else $error("input ready right after a record's last sample");

endmodule

>>> tb/derivative_threshold_crossing_core_tb.sv
// Self-checking testbench of the derivative threshold crossing core.
`timescale 1ns / 1ps

module derivative_threshold_crossing_core_tb;

    import dtc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_ITEMS   = 22;

    // How a directed row sets its expectation
    localparam int FROM_PREDICTOR = -1;
    localparam int NO_WORD        = 0;
    localparam int END_WORD_ONLY  = 1;

    typedef enum int {ROW_SAMPLE, ROW_CONFIG} t_row_op;

    // Sample row: a = value, b = record end. Config row: a = step, b = cut.
    typedef struct {
        t_row_op op;
        int      a;
        int      b;
        int      typed;
    } t_dir_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic signed [SMP_W-1:0] i_sample_value;
    logic                    i_record_end;
    logic                    o_valid;
    logic                    i_ready;
    logic                    o_crossing_found;
    logic [BIN_W-1:0]        o_crossing_bin;
    logic [KIND_W-1:0]       o_crossing_kind;
    logic                    o_run_last;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_data;

    derivative_threshold_crossing_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample_value   (i_sample_value),
        .i_record_end     (i_record_end),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_crossing_found (o_crossing_found),
        .o_crossing_bin   (o_crossing_bin),
        .o_crossing_kind  (o_crossing_kind),
        .o_run_last       (o_run_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    // Crossing predictor state
    longint      rec_samples [MAX_RECORD];
    int          rec_len;
    int          held_step;
    longint      last_deriv;
    int          step_reg;
    longint      cut_reg;

    t_res        crossings_due [$];
    t_res        step_results [$];
    t_dir_row    dir_rows [$];

    int          send_idle_pct;
    int          recv_stall_pct;
    int          fails;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // Append one row to the directed table
    function automatic void add_row(t_row_op op, int a, int b, int typed);
        t_dir_row r;
        r.op    = op;
        r.a     = a;
        r.b     = b;
        r.typed = typed;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // Boxcar derivative of bin i with half width n over the current record
    function automatic longint boxcar_deriv(int i, int n);
        longint fwd;
        longint back;
        fwd  = 0;
        back = 0;
        for (int j = 1; j <= n; j++) begin
            fwd  += rec_samples[i + j];
            back += rec_samples[i - j];
        end
        return fwd - back;
    endfunction

    // Crossing type between the previous and the current derivative, -1 for none
    function automatic int crossing_type(longint vj, longint vi, longint c);
        if (vj > c && vi < -c) return int'(KIND_DOWN_JUMP);
        if (vj < -c && vi > c) return int'(KIND_UP_JUMP);
        if ((vi > c && vj < c) || (vi < c && vj > c)) return int'(KIND_UPPER);
        if ((vi < -c && vj > -c) || (vi > -c && vj < -c)) return int'(KIND_LOWER);
        return -1;
    endfunction

    function automatic void settle_bin(int i, int n);
        longint d;
        int     kc;
        t_res   r;
        d = boxcar_deriv(i, n);
        if (i != 0) begin
            kc = crossing_type(last_deriv, d, cut_reg);
            if (kc >= 0) begin
                r.found = 1'b1;
                r.bin   = BIN_W'(i);
                r.kind  = t_kind'(kc[KIND_W-1:0]);
                r.last  = 1'b0;
                step_results.insert(step_results.size(), r);
            end
        end
        last_deriv = d;
    endfunction

    function automatic t_res end_word();
        t_res r;
        r.found = 1'b0;
        r.bin   = '0;
        r.kind  = KIND_UPPER;
        r.last  = 1'b1;
        return r;
    endfunction

    // Work out the result words caused by one accepted sample
    function automatic void predict_crossings(logic signed [SMP_W-1:0] smp, logic rec_end);
        int k;
        int n;
        int lo;
        bit last;
        step_results.delete();
        k    = rec_len;
        last = rec_end || (k >= MAX_RECORD - 1);
        if (k == 0) begin
            held_step  = (step_reg < MAX_STEP) ? step_reg : MAX_STEP;
            last_deriv = 0;
        end
        rec_samples[k] = longint'(smp);
        if (!last) begin
            if (k >= held_step) begin
                lo = k - held_step;
                settle_bin(lo, (held_step < lo) ? held_step : lo);
            end
            rec_len = k + 1;
        end else begin
            lo = (k >= held_step) ? k - held_step : 0;
            for (int i = lo; i <= k; i++) begin
                n = (held_step < i) ? held_step : i;
                n = (n < k - i) ? n : k - i;
                settle_bin(i, n);
            end
            step_results.insert(step_results.size(), end_word());
            rec_len    = 0;
            last_deriv = 0;
        end
    endfunction

    // Offer one sample word, hold it until accepted, then queue its expected results
    task automatic send_word(logic signed [SMP_W-1:0] smp, logic rec_end, int typed);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_value <= smp;
        i_record_end   <= rec_end;
        do @(posedge i_clk); while (!o_ready);
        predict_crossings(smp, rec_end);
        if (typed == FROM_PREDICTOR) begin
            foreach (step_results[q]) crossings_due.insert(crossings_due.size(), step_results[q]);
        end else if (typed == END_WORD_ONLY) begin
            crossings_due.insert(crossings_due.size(), end_word());
        end
    endtask

    // Drain the block, then write both registers
    task automatic write_config(int step, int cut);
        i_valid <= 1'b0;
        while (crossings_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_DIFF_STEP;
        i_cfg_data <= CFG_W'(step);
        @(posedge i_clk);
        step_reg   = step & 'h1F;
        i_cfg_idx  <= REG_CUT_LEVEL;
        i_cfg_data <= CFG_W'(cut);
        @(posedge i_clk);
        cut_reg    = longint'(cut & 'h1FFFFF);
        i_cfg_we   <= 1'b0;
    endtask

    // One record: full-range noise, small noise, or small noise with a pulse
    task automatic send_record(int len, bit with_end, int mode);
        int pos;
        int width;
        int amp;
        int noise;
        int v;
        logic signed [SMP_W-1:0] smp;
        if (mode < 0) mode = $urandom_range(2);
        pos   = $urandom_range(len - 1);
        width = $urandom_range(1, 8);
        amp   = int'($urandom_range(60000)) - 30000;
        noise = $urandom_range(1, 400);
        for (int j = 0; j < len; j++) begin
            v = int'($urandom_range(2 * noise)) - noise;
            if (mode == 2 && j >= pos && j < pos + width) v += amp;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            smp = (mode == 0) ? SMP_W'($urandom) : SMP_W'(v);
            send_word(smp, with_end && (j == len - 1), FROM_PREDICTOR);
        end
    endtask

    function automatic int pick_step();
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            2: return MAX_STEP;
            3: return $urandom_range(MAX_STEP + 1, 31);
            default: return $urandom_range(1, MAX_STEP);
        endcase
    endfunction

    function automatic int pick_cut();
        case ($urandom_range(7))
            0: return 0;
            1: return 1048576;
            2: return $urandom_range(100);
            3, 4: return $urandom_range(500, 5000);
            default: return $urandom_range(5000, 100000);
        endcase
    endfunction

    // Result side: random stalls
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_res got;
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            got.found = o_crossing_found;
            got.bin   = o_crossing_bin;
            got.kind  = t_kind'(o_crossing_kind);
            got.last  = o_run_last;
            if (crossings_due.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected word: found=%0d bin=%0d kind=%0d last=%0d",
                             got.found, got.bin, got.kind, got.last);
            end else begin
                want = crossings_due.pop_front();
                if (got.found !== want.found || got.bin !== want.bin ||
                    got.kind !== want.kind || got.last !== want.last) begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch: expected found=%0d bin=%0d kind=%0d last=%0d,",
                                 want.found, want.bin, want.kind, want.last,
                                 " got found=%0d bin=%0d kind=%0d last=%0d",
                                 got.found, got.bin, got.kind, got.last);
                end
            end
        end
    end

    // End the run when no word moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("FAIL derivative_threshold_crossing_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int sent;
        int len;
        bit first;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_sample_value = '0;
        i_record_end   = 1'b0;
        i_ready        = 1'b1;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_DIFF_STEP;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fails          = 0;
        quiet_cycles   = 0;
        rec_len        = 0;
        held_step      = 0;
        last_deriv     = 0;
        step_reg       = 1;
        cut_reg        = 0;

        // Single-sample record right after reset: only the end word
        add_row(ROW_SAMPLE, 100, 1, END_WORD_ONLY);
        // Steps and jumps at step 1, with both sample extremes
        add_row(ROW_CONFIG, 1, 1000, NO_WORD);
        add_row(ROW_SAMPLE, 0, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, 0, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, 5000, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, 5000, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, 0, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, -5000, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, -5000, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, 32767, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, -32768, 1, FROM_PREDICTOR);
        // Step above the maximum saturates; a cut of 1048576
        add_row(ROW_CONFIG, 31, 1048576, NO_WORD);
        add_row(ROW_SAMPLE, 32767, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, -32768, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, 32767, 1, FROM_PREDICTOR);
        // Step zero: no crossings even at cut zero
        add_row(ROW_CONFIG, 0, 0, NO_WORD);
        add_row(ROW_SAMPLE, 32767, 0, NO_WORD);
        add_row(ROW_SAMPLE, -32768, 0, NO_WORD);
        add_row(ROW_SAMPLE, 1, 1, END_WORD_ONLY);
        // Step change inside a record waits for the next record
        add_row(ROW_CONFIG, 3, 500, NO_WORD);
        add_row(ROW_SAMPLE, 0, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, 3000, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, -3000, 0, FROM_PREDICTOR);
        add_row(ROW_CONFIG, 1, 500, NO_WORD);
        add_row(ROW_SAMPLE, 4000, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, -4000, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, 2000, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, -1, 0, FROM_PREDICTOR);
        add_row(ROW_SAMPLE, 0, 1, FROM_PREDICTOR);

        // Hold reset, then release
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].op == ROW_CONFIG)
                write_config(dir_rows[r].a, dir_rows[r].b);
            else
                send_word(SMP_W'(dir_rows[r].a), dir_rows[r].b[0], dir_rows[r].typed);
        end

        // Random records under each idling mix
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            sent  = 0;
            first = 1'b1;
            while (sent < RANDOM_ITEMS) begin
                if (first || $urandom_range(1) == 0) write_config(pick_step(), pick_cut());
                first = 1'b0;
                len = ($urandom_range(7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
                send_record(len, 1'b1, -1);
                sent += len;
            end
        end

        // Drain and settle
        i_valid <= 1'b0;
        while (crossings_due.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        fails += crossings_due.size();
        if (fails == 0)
            $display("PASS derivative_threshold_crossing_core");
        else
            $display("FAIL derivative_threshold_crossing_core");
        $finish;
    end

endmodule

>>> sim.f
rtl/dtc_pkg.sv
rtl/dtc_cell.sv
rtl/dtc_tree.sv
rtl/dtc_ofifo.sv
rtl/derivative_threshold_crossing_core.sv
tb/derivative_threshold_crossing_core_tb.sv
